@@ rtl/mslp_pkg.sv @@
// Shared types and constants for the motor slew limit and pulse output block.
`default_nettype none
package mslp_pkg;

  localparam int ACTION_W   = 2;
  localparam int MOTOR_W    = 3;
  localparam int THR_W      = 17;
  localparam int CMP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Adjusted throttle at or above this sets the calibrate-high latch (0.1 full scale).
  localparam logic [THR_W-1:0] CAL_SPLIT = 17'd6554;

  localparam logic [ACTION_W-1:0] ACT_ARMED     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CALIBRATE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DISARMED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RES_REDUX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_D    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISARM     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DISARM_3D  = 3'd7;

  typedef struct packed {
    logic             res_redux_enable;
    logic             three_d_mode;
    logic [CMP_W-1:0] pulse_range;
    logic [CMP_W-1:0] idle_pulse;
    logic [CMP_W-1:0] calibrate_low_pulse;
    logic [CMP_W-1:0] calibrate_high_pulse;
    logic [CMP_W-1:0] disarm_pulse;
    logic [CMP_W-1:0] disarm_pulse_3d;
  } cfg_t;

  typedef struct packed {
    logic                output_enabled;
    logic [THR_W-1:0]    throttle;
    logic [MOTOR_W-1:0]  motor_index;
    logic [ACTION_W-1:0] action;
  } in_item_t;

  typedef struct packed {
    logic                cal_high;
    logic [THR_W-1:0]    throttle;
    logic [MOTOR_W-1:0]  motor_index;
    logic [ACTION_W-1:0] action;
  } lim_item_t;

  typedef struct packed {
    logic [CMP_W-1:0]   compare_value;
    logic [MOTOR_W-1:0] out_motor;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/mslp_regs.sv @@
// Configuration register file written through the plain write port.
`default_nettype none
module mslp_regs
  import mslp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RES_REDUX: cfg.res_redux_enable     <= cfg_data[0];
        REG_THREE_D:   cfg.three_d_mode         <= cfg_data[0];
        REG_RANGE:     cfg.pulse_range          <= cfg_data;
        REG_IDLE:      cfg.idle_pulse           <= cfg_data;
        REG_CAL_LOW:   cfg.calibrate_low_pulse  <= cfg_data;
        REG_CAL_HIGH:  cfg.calibrate_high_pulse <= cfg_data;
        REG_DISARM:    cfg.disarm_pulse         <= cfg_data;
        REG_DISARM_3D: cfg.disarm_pulse_3d      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/mslp_limit.sv @@
// Per-motor deadband hold and slew limiting, calibrate latch, and the stage register after it.
`default_nettype none
module mslp_limit
  import mslp_pkg::*;
#(
  parameter int MOTORS    = 8,
  parameter int DEADBAND  = 164,
  parameter int SLEW_STEP = 33
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire logic res_redux_enable,
  input  in_item_t  item,
  output logic      keep,
  output lim_item_t lim_q
);

  localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam logic [THR_W-1:0] DB   = THR_W'(DEADBAND);
  localparam logic [THR_W-1:0] STEP = THR_W'(SLEW_STEP);

  logic [THR_W-1:0] prev_thr [MOTORS];
  logic             cal_latch;

  logic [IDX_W-1:0] slot;
  logic             in_range;
  logic [THR_W-1:0] prev;
  logic             up;
  logic [THR_W-1:0] diff;
  logic [THR_W-1:0] adj;
  logic             wr_prev;
  logic             is_motor0;
  logic             cal_high;

  always_comb begin
    in_range  = int'(item.motor_index) < MOTORS;
    slot      = IDX_W'(item.motor_index);
    prev      = prev_thr[slot];
    up        = item.throttle > prev;
    diff      = up ? (item.throttle - prev) : (prev - item.throttle);
    adj       = item.throttle;
    wr_prev   = 1'b0;
    if (res_redux_enable) begin
      if (diff <= DB) begin
        adj = prev;
      end else begin
        wr_prev = 1'b1;
        if (diff > STEP) begin
          adj = up ? (prev + STEP) : (prev - STEP);
        end
      end
    end
    is_motor0 = item.motor_index == '0;
    // motor 0 refreshes the latch before its own output is chosen
    cal_high  = is_motor0 ? (adj >= CAL_SPLIT) : cal_latch;
    keep      = in_range && item.output_enabled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        prev_thr[i] <= '0;
      end
      cal_latch <= 1'b0;
    end else if (load && in_range) begin
      if (wr_prev) begin
        prev_thr[slot] <= adj;
      end
      if (is_motor0) begin
        cal_latch <= cal_high;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lim_q.cal_high    <= cal_high;
      lim_q.throttle    <= adj;
      lim_q.motor_index <= item.motor_index;
      lim_q.action      <= item.action;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mslp_map.sv @@
// Compare value selection by action, with the armed throttle scaling, into the result register.
`default_nettype none
module mslp_map
  import mslp_pkg::*;
(
  input  wire logic clk,
  input  wire logic load,
  input  cfg_t      cfg,
  input  lim_item_t lim,
  output out_item_t res_q
);

  logic [THR_W+CMP_W-1:0] prod;
  logic [CMP_W-1:0]       cmp;

  always_comb begin
    prod = {{CMP_W{1'b0}}, lim.throttle} * {{THR_W{1'b0}}, cfg.pulse_range};
    case (lim.action)
      ACT_ARMED: begin
        cmp = prod[CMP_W+15:16] + cfg.idle_pulse;
      end
      ACT_CALIBRATE: begin
        cmp = lim.cal_high ? cfg.calibrate_high_pulse : cfg.calibrate_low_pulse;
      end
      default: begin
        // disarmed, and the unused code acts the same
        cmp = cfg.three_d_mode ? cfg.disarm_pulse_3d : cfg.disarm_pulse;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q.out_motor     <= lim.motor_index;
      res_q.compare_value <= cmp;
    end
  end

endmodule
`default_nettype wire

@@ rtl/motor_slew_limit_pulse_out_top.sv @@
// Top level: motor throttle slew limiter and timer compare value generator.
//
//   channel   | direction | handshake                     | payload
//   s_axis    | in        | s_axis_tvalid / s_axis_tready | action, motor, throttle, enable
//   m_axis    | out       | m_axis_tvalid / m_axis_tready | out_motor, compare_value
//   cfg       | in        | cfg_wr_en (no wait)           | cfg_index, cfg_data
//
// One item per cycle sustained while m_axis does not stall; an accepted item passes
// through the input register, then the limiter stage register, then the result
// register, from which its result is presented on m_axis.
// The previous-value registers update as the item leaves the input register, so the
// next item for the same motor sees them in the following cycle.
// Reset clears all valid flags, configuration, previous values and the latch at once.
// A stall on m_axis holds each full stage; empty stages keep accepting.
`default_nettype none
module motor_slew_limit_pulse_out_top
  import mslp_pkg::*;
#(
  parameter int MOTORS    = 8,
  parameter int DEADBAND  = 164,
  parameter int SLEW_STEP = 33
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [1:0] action, [4:2] motor_index, [21:5] throttle, [22] output_enabled, [23] unused
  input  wire logic [23:0]           s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [2:0] out_motor, [18:3] compare_value, [23:19] zero
  output logic [23:0]                m_axis_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  in_q;
  lim_item_t lim_q;
  out_item_t res_q;
  logic      keep;

  logic v0, v1, v2;
  logic r0, r1, r2;

  assign r2 = !v2 || m_axis_tready;
  assign r1 = !v1 || r2;
  assign r0 = !v0 || r1;
  assign s_axis_tready = r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r0) v0 <= s_axis_tvalid;
      // drop items that give no result once their state update is done
      if (r1) v1 <= v0 && keep;
      if (r2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && r0) begin
      in_q <= s_axis_tdata[22:0];
    end
  end

  mslp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mslp_limit #(
    .MOTORS    (MOTORS),
    .DEADBAND  (DEADBAND),
    .SLEW_STEP (SLEW_STEP)
  ) u_limit (
    .clk              (clk),
    .rst              (rst),
    .load             (v0 && r1),
    .res_redux_enable (cfg.res_redux_enable),
    .item             (in_q),
    .keep             (keep),
    .lim_q            (lim_q)
  );

  mslp_map u_map (
    .clk   (clk),
    .load  (v1 && r2),
    .cfg   (cfg),
    .lim   (lim_q),
    .res_q (res_q)
  );

  assign m_axis_tvalid = v2;
  assign m_axis_tdata  = {5'b0, res_q};

endmodule
`default_nettype wire

@@ rtl/mslp_checker.sv @@
// Port-level checks for the top level, attached by bind.
`default_nettype none
module mslp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // with the result register empty every stage can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:19] == 5'b0)
    else $error("padding bits of result not zero");

endmodule

bind motor_slew_limit_pulse_out_top mslp_checker u_mslp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
